FILE: rtl/hkrb_pkg.sv
package hkrb_pkg;

    localparam int SLOT_COUNT    = 6;
    localparam int REPORT_SLOTS  = 6;
    localparam int ROM_SIZE      = 195;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CODE_LCTRL  = 16'd29;
    localparam logic [15:0] CODE_LSHIFT = 16'd42;
    localparam logic [15:0] CODE_LALT   = 16'd56;
    localparam logic [15:0] CODE_LGUI   = 16'd125;
    localparam logic [15:0] CODE_RCTRL  = 16'd97;
    localparam logic [15:0] CODE_RSHIFT = 16'd54;
    localparam logic [15:0] CODE_RALT   = 16'd100;
    localparam logic [15:0] CODE_RGUI   = 16'd126;

    localparam logic [7:0] USAGE_EMPTY = 8'h00;

    typedef struct packed {
        logic [15:0] key_code;
        logic        pressed;
    } hkrb_in_t;

    typedef struct packed {
        logic [7:0] modifier_byte;
        logic [7:0] slot0_usage;
        logic [7:0] slot1_usage;
        logic [7:0] slot2_usage;
        logic [7:0] slot3_usage;
        logic [7:0] slot4_usage;
        logic [7:0] slot5_usage;
    } hkrb_out_t;

    typedef enum logic [1:0] {
        EVT_NONE,
        EVT_MOD,
        EVT_KEY
    } hkrb_kind_t;

    // value carries the modifier mask for EVT_MOD and the usage for EVT_KEY
    typedef struct packed {
        hkrb_kind_t kind;
        logic       pressed;
        logic [7:0] value;
    } hkrb_evt_t;

    localparam logic [7:0] USAGE_ROM [ROM_SIZE] = '{
        8'h00,8'h29,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,
        8'h26,8'h27,8'h2d,8'h2e,8'h2a,8'h2b,8'h14,8'h1a,8'h08,8'h15,
        8'h17,8'h1c,8'h18,8'h0c,8'h12,8'h13,8'h2f,8'h30,8'h28,8'he0,
        8'h04,8'h16,8'h07,8'h09,8'h0a,8'h0b,8'h0d,8'h0e,8'h0f,8'h33,
        8'h34,8'h35,8'he1,8'h31,8'h1d,8'h1b,8'h06,8'h19,8'h05,8'h11,
        8'h10,8'h36,8'h37,8'h38,8'he5,8'h55,8'he2,8'h2c,8'h39,8'h3a,
        8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,8'h40,8'h41,8'h42,8'h43,8'h53,
        8'h47,8'h5f,8'h60,8'h61,8'h56,8'h5c,8'h5d,8'h5e,8'h57,8'h59,
        8'h5a,8'h5b,8'h62,8'h63,8'h00,8'h94,8'h64,8'h44,8'h45,8'h87,
        8'h92,8'h93,8'h8a,8'h88,8'h8b,8'h00,8'h58,8'he4,8'h54,8'h46,
        8'he6,8'h00,8'h4a,8'h52,8'h4b,8'h50,8'h4f,8'h4d,8'h51,8'h4e,
        8'h49,8'h4c,8'h00,8'h7f,8'h81,8'h80,8'h66,8'h67,8'hd7,8'h48,
        8'h00,8'h85,8'h90,8'h91,8'h89,8'he3,8'he7,8'h65,8'h00,8'h79,
        8'h00,8'h7a,8'h77,8'h7c,8'h74,8'h7d,8'h7e,8'h7b,8'h75,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hb6,
        8'hb7,8'h00,8'h00,8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,
        8'h6f,8'h70,8'h71,8'h72,8'h73
    };

    function automatic logic [7:0] modifier_mask(input logic [15:0] code);
        logic [7:0] mask;
        mask = 8'h00;
        unique case (code)
            CODE_LCTRL:  mask = 8'h01;
            CODE_LSHIFT: mask = 8'h02;
            CODE_LALT:   mask = 8'h04;
            CODE_LGUI:   mask = 8'h08;
            CODE_RCTRL:  mask = 8'h10;
            CODE_RSHIFT: mask = 8'h20;
            CODE_RALT:   mask = 8'h40;
            CODE_RGUI:   mask = 8'h80;
            default:     mask = 8'h00;
        endcase
        return mask;
    endfunction

endpackage

FILE: rtl/hkrb_front.sv
module hkrb_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  hkrb_pkg::hkrb_in_t s_data,
    output logic               push,
    input  logic               q_ready,
    output hkrb_pkg::hkrb_evt_t evt
);

    logic [7:0] mask;
    logic [7:0] usage;
    logic       in_rom;

    assign s_ready = q_ready;
    assign push    = s_valid && q_ready;

    assign mask   = hkrb_pkg::modifier_mask(s_data.key_code);
    assign in_rom = s_data.key_code < 16'(hkrb_pkg::ROM_SIZE);
    assign usage  = in_rom ? hkrb_pkg::USAGE_ROM[s_data.key_code[7:0]] : hkrb_pkg::USAGE_EMPTY;

    always_comb begin
        evt.pressed = s_data.pressed;
        if (mask != 8'h00) begin
            evt.kind  = hkrb_pkg::EVT_MOD;
            evt.value = mask;
        end else if (usage != hkrb_pkg::USAGE_EMPTY) begin
            evt.kind  = hkrb_pkg::EVT_KEY;
            evt.value = usage;
        end else begin
            evt.kind  = hkrb_pkg::EVT_NONE;
            evt.value = hkrb_pkg::USAGE_EMPTY;
        end
    end

endmodule

FILE: rtl/hkrb_queue.sv
module hkrb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    output logic                q_ready,
    input  hkrb_pkg::hkrb_evt_t push_evt,
    output logic                q_valid,
    input  logic                pop,
    output hkrb_pkg::hkrb_evt_t pop_evt
);

    hkrb_pkg::hkrb_evt_t              entry_reg [hkrb_pkg::QUEUE_DEPTH];
    logic [hkrb_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hkrb_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hkrb_pkg::QCNT_W-1:0]      count_reg, count_next;

    localparam logic [hkrb_pkg::QCNT_W-1:0] FULL_COUNT = hkrb_pkg::QCNT_W'(hkrb_pkg::QUEUE_DEPTH);
    localparam logic [hkrb_pkg::QPTR_W-1:0] LAST_PTR   = hkrb_pkg::QPTR_W'(hkrb_pkg::QUEUE_DEPTH - 1);

    assign q_ready = count_reg != FULL_COUNT;
    assign q_valid = count_reg != '0;
    assign pop_evt = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_evt;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == FULL_COUNT && !pop |-> !push)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

FILE: rtl/hkrb_back.sv
module hkrb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                pop,
    input  hkrb_pkg::hkrb_evt_t evt,
    output logic                m_valid,
    input  logic                m_ready,
    output hkrb_pkg::hkrb_out_t m_data
);

    logic [7:0]                                modifier_reg, modifier_next;
    logic [hkrb_pkg::SLOT_COUNT-1:0][7:0]      slot_reg, slot_next;
    logic [hkrb_pkg::SLOT_COUNT-1:0]           hit;
    logic [hkrb_pkg::SLOT_COUNT-1:0]           first_empty;
    logic [hkrb_pkg::REPORT_SLOTS-1:0][7:0]    rep_slots;
    logic                                      m_valid_reg, m_valid_next;
    hkrb_pkg::hkrb_out_t                       report_reg, report_next;

    assign pop     = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = report_reg;

    always_comb begin
        logic found;
        found       = 1'b0;
        hit         = '0;
        first_empty = '0;
        for (int i = 0; i < hkrb_pkg::SLOT_COUNT; i++) begin
            hit[i] = slot_reg[i] == evt.value;
            if (slot_reg[i] == hkrb_pkg::USAGE_EMPTY && !found) begin
                first_empty[i] = 1'b1;
                found          = 1'b1;
            end
        end
    end

    always_comb begin
        modifier_next = modifier_reg;
        slot_next     = slot_reg;
        if (pop) begin
            unique case (evt.kind)
                hkrb_pkg::EVT_MOD: begin
                    modifier_next = evt.pressed ? (modifier_reg | evt.value)
                                                : (modifier_reg & ~evt.value);
                end
                hkrb_pkg::EVT_KEY: begin
                    for (int i = 0; i < hkrb_pkg::SLOT_COUNT; i++) begin
                        if (!evt.pressed && hit[i]) begin
                            slot_next[i] = hkrb_pkg::USAGE_EMPTY;
                        end else if (evt.pressed && !(|hit) && first_empty[i]) begin
                            slot_next[i] = evt.value;
                        end
                    end
                end
                hkrb_pkg::EVT_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar j = 0; j < hkrb_pkg::REPORT_SLOTS; j++) begin : g_rep
        if (j < hkrb_pkg::SLOT_COUNT) begin : g_live
            assign rep_slots[j] = slot_next[j];
        end else begin : g_none
            assign rep_slots[j] = hkrb_pkg::USAGE_EMPTY;
        end
    end

    always_comb begin
        report_next.modifier_byte = modifier_next;
        report_next.slot0_usage   = rep_slots[0];
        report_next.slot1_usage   = rep_slots[1];
        report_next.slot2_usage   = rep_slots[2];
        report_next.slot3_usage   = rep_slots[3];
        report_next.slot4_usage   = rep_slots[4];
        report_next.slot5_usage   = rep_slots[5];
        m_valid_next = m_valid_reg;
        priority if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modifier_reg <= '0;
            slot_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            modifier_reg <= modifier_next;
            slot_reg     <= slot_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            report_reg <= report_next;
        end
    end

    a_mod_keeps_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && evt.kind == hkrb_pkg::EVT_MOD |=> slot_reg == $past(slot_reg))
        else $error("modifier request changed key slots");

    a_key_keeps_mods: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && evt.kind != hkrb_pkg::EVT_MOD |=> modifier_reg == $past(modifier_reg))
        else $error("non-modifier request changed modifier byte");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(slot_reg) && $stable(modifier_reg))
        else $error("state changed without a request");

endmodule

FILE: rtl/hid_keyboard_report_builder_unit.sv
// channel | ports                      | payload
// --------+----------------------------+----------------------------------------
// input   | s_valid s_ready s_data     | key_code, pressed
// output  | m_valid m_ready m_data     | modifier_byte, slot0_usage..slot5_usage
//
// One request per cycle sustained while the report output is not stalled; one report per request.
// The front writes the 2-entry queue, the back updates state
// and loads the report register from it.
// Reset clears modifiers, key slots, queue and output valid.
// s_ready drops only when both queue entries are held while the report waits.
module hid_keyboard_report_builder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hkrb_pkg::hkrb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hkrb_pkg::hkrb_out_t m_data
);

    logic                push;
    logic                q_ready;
    logic                q_valid;
    logic                pop;
    hkrb_pkg::hkrb_evt_t push_evt;
    hkrb_pkg::hkrb_evt_t pop_evt;

    hkrb_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .push    (push),
        .q_ready (q_ready),
        .evt     (push_evt)
    );

    hkrb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .q_ready  (q_ready),
        .push_evt (push_evt),
        .q_valid  (q_valid),
        .pop      (pop),
        .pop_evt  (pop_evt)
    );

    hkrb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .pop     (pop),
        .evt     (pop_evt),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
